>>> rtl/upd_pkg.sv
// upd_pkg: shared types, character constants and escape decoding functions
// for the URL percent decoder. Depends on nothing; all files but upd_stream_if use it.

package upd_pkg;

	localparam logic [7:0] CH_PLUS    = 8'h2B;
	localparam logic [7:0] CH_PERCENT = 8'h25;
	localparam logic [7:0] CH_QUERY   = 8'h3F;
	localparam logic [7:0] CH_SPACE   = 8'h20;
	localparam logic [7:0] CH_MINUS   = 8'h2D;
	localparam logic [7:0] CH_TAB     = 8'h09;
	localparam logic [7:0] CH_CR      = 8'h0D;

	localparam int unsigned HEX_BASE    = 16;
	localparam int unsigned QUEUE_DEPTH = 2;
	localparam int unsigned QPTR_BITS   = $clog2(QUEUE_DEPTH);
	localparam int unsigned QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

	localparam int unsigned CAP_BITS   = 16;
	localparam int unsigned OCOUNT_BITS = 16;

	// One word that the front end hands to the back end: a byte to be
	// counted and emitted, and the end-of-string mark.
	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} op_t;

	typedef struct packed {
		logic       ok;
		logic [3:0] val;
	} hex_t;

	function automatic hex_t hex_value(input logic [7:0] c);
		hex_t h;
		h = '{ok: 1'b0, val: 4'd0};
		if (c >= 8'h30 && c <= 8'h39) begin
			h = '{ok: 1'b1, val: 4'(c - 8'h30)};
		end else if (c >= 8'h61 && c <= 8'h66) begin
			h = '{ok: 1'b1, val: 4'(c - 8'h57)};
		end else if (c >= 8'h41 && c <= 8'h46) begin
			h = '{ok: 1'b1, val: 4'(c - 8'h37)};
		end
		return h;
	endfunction

	function automatic logic is_blank(input logic [7:0] c);
		return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
	endfunction

	// Two-character escape value with base-16 integer parsing rules: an
	// optional blank or sign, then up to two hex digits, zero if none.
	function automatic logic [7:0] escape_value(input logic [7:0] c1, input logic has2,
			input logic [7:0] c2);
		hex_t h1;
		hex_t h2;
		logic [7:0] v;
		h1 = hex_value(c1);
		h2 = hex_value(c2);
		h2.ok = h2.ok & has2;
		v = 8'd0;
		if (h1.ok) begin
			v = h2.ok ? {h1.val, h2.val} : {4'd0, h1.val};
		end else if (is_blank(c1) || c1 == CH_PLUS) begin
			v = h2.ok ? {4'd0, h2.val} : 8'd0;
		end else if (c1 == CH_MINUS) begin
			v = h2.ok ? 8'(8'd0 - {4'd0, h2.val}) : 8'd0;
		end
		return v;
	endfunction

endpackage

>>> rtl/upd_stream_if.sv
// Stream interfaces of the URL percent decoder: one for encoded input
// characters and one for decoded results. Depends on nothing.

interface upd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       in_last;

	modport source (output valid, output in_byte, output in_last, input ready);
	modport sink (input valid, input in_byte, input in_last, output ready);
endinterface

interface upd_out_if;
	logic        valid;
	logic        ready;
	logic [7:0]  out_byte;
	logic        status;
	logic        out_last;
	logic [15:0] out_count;

	modport source (output valid, output out_byte, output status, output out_last,
		output out_count, input ready);
	modport sink (input valid, input out_byte, input status, input out_last,
		input out_count, output ready);
endinterface

>>> rtl/upd_front.sv
// Front end: accepts encoded characters, tracks escapes and the query tail,
// and pushes one op per character that yields a byte. Depends on upd_pkg.

module upd_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  logic [7:0]      in_byte,
	input  logic            in_last,
	input  logic            q_full,
	output logic            in_ready,
	output logic            push,
	output upd_pkg::op_t    push_op
);

	typedef enum logic [1:0] {
		MODE_NORMAL,
		MODE_HEX1,
		MODE_HEX2,
		MODE_QUERY
	} mode_t;

	mode_t       mode_q;
	mode_t       mode_d;
	logic [7:0]  first_q;
	logic [7:0]  first_d;
	logic        emit;
	logic        accept;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;
	assign push     = accept && emit;

	always_comb begin
		emit         = 1'b0;
		push_op.data = in_byte;
		push_op.last = in_last;
		mode_d       = mode_q;
		first_d      = first_q;
		unique case (mode_q)
			MODE_HEX1: begin
				if (in_last) begin
					emit         = 1'b1;
					push_op.data = upd_pkg::escape_value(in_byte, 1'b0, 8'd0);
				end else begin
					first_d = in_byte;
					mode_d  = MODE_HEX2;
				end
			end
			MODE_HEX2: begin
				emit         = 1'b1;
				push_op.data = upd_pkg::escape_value(first_q, 1'b1, in_byte);
				mode_d       = MODE_NORMAL;
				first_d      = 8'd0;
			end
			MODE_QUERY: begin
				emit = 1'b1;
			end
			MODE_NORMAL: begin
				priority if (in_byte == upd_pkg::CH_PLUS) begin
					emit         = 1'b1;
					push_op.data = upd_pkg::CH_SPACE;
				end else if (in_byte == upd_pkg::CH_PERCENT) begin
					if (in_last) begin
						emit         = 1'b1;
						push_op.data = 8'd0;
					end else begin
						mode_d = MODE_HEX1;
					end
				end else if (in_byte == upd_pkg::CH_QUERY) begin
					emit   = 1'b1;
					mode_d = MODE_QUERY;
				end else begin
					emit = 1'b1;
				end
			end
			default: begin
				mode_d = MODE_NORMAL;
			end
		endcase
		// Every string starts fresh after its final character.
		if (in_last) begin
			mode_d  = MODE_NORMAL;
			first_d = 8'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_NORMAL;
			first_q <= 8'd0;
		end else if (accept) begin
			mode_q  <= mode_d;
			first_q <= first_d;
		end
	end

endmodule

>>> rtl/upd_queue.sv
// Two-entry queue of ops between the front end and the back end.
// Depends on upd_pkg for the op type and depth.

module upd_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  upd_pkg::op_t    push_op,
	input  logic            pop,
	output logic            full,
	output logic            nonempty,
	output upd_pkg::op_t    head
);

	upd_pkg::op_t                     mem_q [upd_pkg::QUEUE_DEPTH];
	logic [upd_pkg::QPTR_BITS-1:0]    wr_ptr_q;
	logic [upd_pkg::QPTR_BITS-1:0]    rd_ptr_q;
	logic [upd_pkg::QCNT_BITS-1:0]    cnt_q;
	logic                             do_push;
	logic                             do_pop;

	assign full     = (cnt_q == upd_pkg::QCNT_BITS'(upd_pkg::QUEUE_DEPTH));
	assign nonempty = (cnt_q != '0);
	assign head     = mem_q[rd_ptr_q];
	assign do_push  = push && !full;
	assign do_pop   = pop && nonempty;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_op;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == upd_pkg::QPTR_BITS'(upd_pkg::QUEUE_DEPTH - 1))
					? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == upd_pkg::QPTR_BITS'(upd_pkg::QUEUE_DEPTH - 1))
					? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

>>> rtl/upd_back.sv
// Back end: counts decoded bytes against the capacity register, raises the
// overflow result, drops the rest of a failed string and holds the output
// word in a register. Depends on upd_pkg.

module upd_back #(
	parameter int unsigned COUNT_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [upd_pkg::CAP_BITS-1:0]  cfg_wr_data,
	input  logic                          q_nonempty,
	input  upd_pkg::op_t                  q_head,
	output logic                          q_pop,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [7:0]                    out_byte,
	output logic                          status,
	output logic                          out_last,
	output logic [upd_pkg::OCOUNT_BITS-1:0] out_count,
	output logic                          err
);

	localparam int unsigned CMP_W = (COUNT_BITS > upd_pkg::CAP_BITS)
		? COUNT_BITS : upd_pkg::CAP_BITS;

	logic [upd_pkg::CAP_BITS-1:0]   cap_q;
	logic [COUNT_BITS-1:0]          count_q;
	logic                           err_q;
	logic                           valid_q;
	logic [7:0]                     byte_q;
	logic                           status_q;
	logic                           last_q;
	logic [upd_pkg::OCOUNT_BITS-1:0] ocount_q;
	logic [COUNT_BITS-1:0]          count_inc;
	logic [CMP_W-1:0]               count_ext;
	logic [CMP_W-1:0]               inc_ext;
	logic [CMP_W-1:0]               cap_ext;
	logic                           over;
	logic                           slot_free;
	logic                           load;

	assign slot_free = !valid_q || out_ready;
	assign q_pop     = q_nonempty && slot_free;
	// Ops that arrive after an overflow are consumed without a result.
	assign load      = q_pop && !err_q;

	assign count_inc = count_q + 1'b1;
	assign count_ext = CMP_W'(count_q);
	assign inc_ext   = CMP_W'(count_inc);
	assign cap_ext   = CMP_W'(cap_q);
	assign over      = (count_ext >= cap_ext) || (&count_q);

	assign out_valid = valid_q;
	assign out_byte  = byte_q;
	assign status    = status_q;
	assign out_last  = last_q;
	assign out_count = ocount_q;
	assign err       = err_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= '1;
		end else if (cfg_wr_en) begin
			cap_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			err_q   <= 1'b0;
			valid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				if (q_head.last) begin
					count_q <= '0;
					err_q   <= 1'b0;
				end else if (!err_q) begin
					if (over) begin
						err_q <= 1'b1;
					end else begin
						count_q <= count_inc;
					end
				end
			end
			if (load) begin
				valid_q <= 1'b1;
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			if (over) begin
				byte_q   <= 8'd0;
				status_q <= 1'b1;
				last_q   <= 1'b1;
				ocount_q <= count_ext[upd_pkg::OCOUNT_BITS-1:0];
			end else begin
				byte_q   <= q_head.data;
				status_q <= 1'b0;
				last_q   <= q_head.last;
				ocount_q <= inc_ext[upd_pkg::OCOUNT_BITS-1:0];
			end
		end
	end

endmodule

>>> rtl/url_percent_decoder.sv
// Top level of the URL percent decoder: front end, op queue and back end.
// Depends on upd_pkg, upd_stream_if, upd_front, upd_queue and upd_back.
//
// Port      Dir  Handshake      Word
// in_ch     in   valid/ready    in_byte[7:0], in_last
// out_ch    out  valid/ready    out_byte[7:0], status, out_last, out_count[15:0]
// cfg       in   cfg_wr_en      cfg_wr_data[15:0] = out_capacity
//
// One character is accepted per clock while the queue is not full; a result
// goes from the front decode into the queue, then from the back end into the
// output register. The queue holds two words, so the input stalls only when
// the output has been stalled long enough to fill it. Reset is asynchronous;
// the capacity resets to 65535 and needs no clearing pass.

module url_percent_decoder #(
	parameter int unsigned COUNT_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	upd_in_if.sink                        in_ch,
	upd_out_if.source                     out_ch,
	input  logic                          cfg_wr_en,
	input  logic [upd_pkg::CAP_BITS-1:0]  cfg_wr_data
);

	logic          q_full;
	logic          q_nonempty;
	logic          push;
	logic          pop;
	upd_pkg::op_t  push_op;
	upd_pkg::op_t  q_head;
	logic          err;

	upd_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_byte  (in_ch.in_byte),
		.in_last  (in_ch.in_last),
		.q_full   (q_full),
		.in_ready (in_ch.ready),
		.push     (push),
		.push_op  (push_op)
	);

	upd_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_op  (push_op),
		.pop      (pop),
		.full     (q_full),
		.nonempty (q_nonempty),
		.head     (q_head)
	);

	upd_back #(
		.COUNT_BITS (COUNT_BITS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.q_nonempty  (q_nonempty),
		.q_head      (q_head),
		.q_pop       (pop),
		.out_valid   (out_ch.valid),
		.out_ready   (out_ch.ready),
		.out_byte    (out_ch.out_byte),
		.status      (out_ch.status),
		.out_last    (out_ch.out_last),
		.out_count   (out_ch.out_count),
		.err         (err)
	);

	// The front end never pushes into a full queue.
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !q_full)
		else $error("op pushed into full queue");

	// An overflow result carries a zero byte and closes the string.
	a_err_word: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && out_ch.status) |-> (out_ch.out_byte == 8'd0 && out_ch.out_last))
		else $error("malformed overflow result");

	// A good result always counts at least one byte.
	a_count_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && !out_ch.status) |-> (out_ch.out_count != 16'd0))
		else $error("good result with zero count");

	// While a string is in overflow, a popped op that does not end it
	// leaves the output register as it was or empty.
	a_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(err && pop && out_ch.ready) |=> !out_ch.valid)
		else $error("result produced after overflow");

endmodule

>>> tb/tb_url_percent_decoder.sv
// tb_url_percent_decoder: self-checking testbench for the URL percent decoder.
// Depends on upd_pkg, the upd_in_if and upd_out_if interfaces and url_percent_decoder.
// A driver and a monitor run under random flow control; an in-line decoder predicts each word.

module tb_url_percent_decoder;

	localparam int unsigned     COUNT_BITS    = 16;
	localparam longint unsigned COUNT_MAX     = (64'd1 << COUNT_BITS) - 1;
	localparam logic [15:0]     CAP_MAX       = 16'hFFFF;
	localparam int unsigned     STALL_LIMIT   = 1000;
	localparam int unsigned     LONG_HOLD     = 60;
	localparam int unsigned     SETTLE_CYCLES = 8;
	localparam string           HEX_CHARS     = "0123456789abcdefABCDEF";

	typedef enum logic [2:0] {DM_NORMAL, DM_HEX1, DM_HEX2, DM_QUERY, DM_ERROR} decode_mode_t;
	typedef enum logic [1:0] {RX_FREE, RX_COIN, RX_SPARSE, RX_PATTERN} rx_style_t;

	typedef struct packed {
		logic [7:0] ch;
		logic       last;
	} enc_char_t;

	typedef struct packed {
		logic [7:0]  data;
		logic        err;
		logic        last;
		logic [15:0] count;
	} decoded_t;

	logic                         clk;
	logic                         arst_n      = 1'b1;
	logic                         cfg_wr_en   = 1'b0;
	logic [upd_pkg::CAP_BITS-1:0] cfg_wr_data = '0;

	upd_in_if  in_if ();
	upd_out_if out_if ();

	url_percent_decoder #(.COUNT_BITS(COUNT_BITS)) i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_ch      (in_if),
		.out_ch     (out_if),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data)
	);

	// Decoder state as the testbench sees it.
	decode_mode_t    dm_mode     = DM_NORMAL;
	logic [7:0]      dm_first    = '0;
	longint unsigned dm_written  = 0;
	logic [15:0]     dm_capacity = CAP_MAX;

	enc_char_t char_queue[$];
	decoded_t  decoded_q[$];

	int unsigned mismatches      = 0;
	int unsigned chars_accepted  = 0;
	int unsigned results_seen    = 0;
	int unsigned overflows_seen  = 0;
	int unsigned input_stalls    = 0;
	int unsigned capacity_writes = 0;
	int unsigned idle_cycles     = 0;

	bit sender_gapless = 1'b0;
	bit hold_req       = 1'b0;
	bit hold_done;

	int unsigned burst_left;
	int unsigned gap_left;
	int unsigned rx_left;
	int unsigned hold_left;
	int unsigned rx_tick;
	rx_style_t   rx_style;

	function automatic int hex_digit(input logic [7:0] c);
		if (c >= "0" && c <= "9") return int'(c) - 48;
		if (c >= "a" && c <= "f") return int'(c) - 87;
		if (c >= "A" && c <= "F") return int'(c) - 55;
		return -1;
	endfunction

	function automatic bit is_space_like(input logic [7:0] c);
		return c == upd_pkg::CH_SPACE || (c >= upd_pkg::CH_TAB && c <= upd_pkg::CH_CR);
	endfunction

	// Base-16 parse of up to two characters: a leading blank or sign may
	// take the place of the first digit.
	function automatic logic [7:0] escape_byte(input logic [7:0] c1, input bit have2,
			input logic [7:0] c2);
		int d1;
		int d2;
		d1 = hex_digit(c1);
		d2 = have2 ? hex_digit(c2) : -1;
		if (d1 >= 0) return (d2 >= 0) ? 8'(d1 * upd_pkg::HEX_BASE + d2) : 8'(d1);
		if (is_space_like(c1) || c1 == upd_pkg::CH_PLUS) return (d2 >= 0) ? 8'(d2) : 8'h00;
		if (c1 == upd_pkg::CH_MINUS) return (d2 >= 0) ? 8'(256 - d2) : 8'h00;
		return 8'h00;
	endfunction

	task automatic end_of_string();
		dm_mode    = DM_NORMAL;
		dm_first   = '0;
		dm_written = 0;
	endtask

	task automatic emit_decoded(input logic [7:0] b, input bit last);
		decoded_t r;
		if (dm_written >= dm_capacity || dm_written >= COUNT_MAX) begin
			r.data  = '0;
			r.err   = 1'b1;
			r.last  = 1'b1;
			r.count = 16'(dm_written);
			if (last) end_of_string();
			else dm_mode = DM_ERROR;
		end else begin
			dm_written = (dm_written + 1) & COUNT_MAX;
			r.data  = b;
			r.err   = 1'b0;
			r.last  = last;
			r.count = 16'(dm_written);
			if (last) end_of_string();
		end
		decoded_q.push_back(r);
	endtask

	task automatic decode_char(input logic [7:0] c, input bit last);
		logic [7:0] v;
		case (dm_mode)
			DM_HEX1: begin
				if (last) begin
					emit_decoded(escape_byte(c, 1'b0, 8'h00), 1'b1);
				end else begin
					dm_first = c;
					dm_mode  = DM_HEX2;
				end
			end
			DM_HEX2: begin
				dm_mode  = DM_NORMAL;
				v        = escape_byte(dm_first, 1'b1, c);
				dm_first = '0;
				emit_decoded(v, last);
			end
			DM_QUERY: emit_decoded(c, last);
			DM_NORMAL: begin
				if (c == upd_pkg::CH_PLUS) begin
					emit_decoded(upd_pkg::CH_SPACE, last);
				end else if (c == upd_pkg::CH_PERCENT) begin
					if (last) emit_decoded(8'h00, 1'b1);
					else dm_mode = DM_HEX1;
				end else begin
					if (c == upd_pkg::CH_QUERY) dm_mode = DM_QUERY;
					emit_decoded(c, last);
				end
			end
			default: begin
				if (last) end_of_string();
			end
		endcase
	endtask

	task automatic report_mismatch(input string what, input longint unsigned got,
			input longint unsigned want);
		mismatches++;
		$display("%0t: %s is %0h, expected %0h", $time, what, got, want);
	endtask

	task automatic push_char(input logic [7:0] c, input bit last);
		enc_char_t e;
		e.ch   = c;
		e.last = last;
		char_queue.push_back(e);
	endtask

	task automatic push_text(input string s);
		for (int i = 0; i < s.len(); i++) push_char(s[i], i == s.len() - 1);
	endtask

	function automatic logic [7:0] pick_escape_char();
		int unsigned sel;
		sel = $urandom_range(0, 9);
		case (sel)
			0, 1, 2, 3, 4, 5: return HEX_CHARS[$urandom_range(0, 21)];
			6: return ($urandom_range(0, 5) == 0) ? upd_pkg::CH_SPACE
				: 8'(upd_pkg::CH_TAB + $urandom_range(0, 4));
			7: return $urandom_range(0, 1) ? upd_pkg::CH_PLUS : upd_pkg::CH_MINUS;
			8: return $urandom_range(0, 1) ? upd_pkg::CH_PERCENT : upd_pkg::CH_QUERY;
			default: return 8'($urandom_range(1, 255));
		endcase
	endfunction

	// Mostly well-formed strings with random content; one in five is noise.
	// Cutting to length leaves some strings ending inside an escape.
	task automatic push_random_string(input int unsigned len);
		logic [7:0]  chars[$];
		bit          in_query;
		int unsigned sel;
		in_query = 1'b0;
		if ($urandom_range(0, 4) == 0) begin
			repeat (len) chars.push_back(8'($urandom_range(1, 255)));
		end else begin
			while (chars.size() < len) begin
				sel = $urandom_range(0, 9);
				if (in_query) begin
					chars.push_back((sel < 5) ? 8'($urandom_range(1, 255))
						: 8'($urandom_range(8'h21, 8'h7E)));
				end else begin
					case (sel)
						0, 1, 2, 3: chars.push_back(8'($urandom_range(8'h61, 8'h7A)));
						4: chars.push_back(upd_pkg::CH_PLUS);
						5, 6, 7: begin
							chars.push_back(upd_pkg::CH_PERCENT);
							chars.push_back(pick_escape_char());
							chars.push_back(pick_escape_char());
						end
						8: begin
							chars.push_back(upd_pkg::CH_QUERY);
							in_query = 1'b1;
						end
						default: chars.push_back(8'($urandom_range(1, 255)));
					endcase
				end
			end
		end
		while (chars.size() > len) void'(chars.pop_back());
		foreach (chars[i]) push_char(chars[i], i == chars.size() - 1);
	endtask

	task automatic push_random_chars(input int unsigned total);
		int unsigned sent;
		int unsigned len;
		sent = 0;
		while (sent < total) begin
			len = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 60) : $urandom_range(1, 16);
			push_random_string(len);
			sent += len;
		end
	endtask

	// Checked at the falling edge, when every update of the last rising edge
	// has landed. Dropped characters give no result, so a settling wait follows.
	task automatic wait_drained();
		do @(negedge clk);
		while (char_queue.size() != 0 || in_if.valid || decoded_q.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_capacity(input logic [15:0] cap);
		wait_drained();
		@(posedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= cap;
		@(posedge clk);
		cfg_wr_en   <= 1'b0;
		dm_capacity = cap;
		capacity_writes++;
	endtask

	initial begin : clock_gen
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk or negedge arst_n) begin : drive_chars
		enc_char_t nxt;
		if (!arst_n) begin
			in_if.valid   <= 1'b0;
			in_if.in_byte <= '0;
			in_if.in_last <= 1'b0;
			burst_left    <= 1;
			gap_left      <= 0;
		end else begin
			if (in_if.valid && in_if.ready) begin
				decode_char(in_if.in_byte, in_if.in_last);
				chars_accepted++;
			end
			if (in_if.valid && !in_if.ready) input_stalls++;
			if (!in_if.valid || in_if.ready) begin
				if (gap_left != 0 && !sender_gapless) begin
					gap_left    <= gap_left - 1;
					in_if.valid <= 1'b0;
				end else if (char_queue.size() != 0) begin
					nxt = char_queue.pop_front();
					in_if.valid   <= 1'b1;
					in_if.in_byte <= nxt.ch;
					in_if.in_last <= nxt.last;
					if (burst_left > 1) begin
						burst_left <= burst_left - 1;
					end else begin
						// Now and then a long burst gives a stretch with no idling.
						burst_left <= ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
							: $urandom_range(1, 20);
						gap_left   <= $urandom_range(1, 12);
					end
				end else begin
					in_if.valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin : check_results
		decoded_t want;
		if (!arst_n) begin
			out_if.ready <= 1'b0;
			rx_left      <= 0;
			hold_left    <= 0;
			hold_done    <= 1'b0;
			rx_tick      <= 0;
			rx_style     <= RX_FREE;
		end else begin
			if (out_if.valid && out_if.ready) begin
				results_seen++;
				if (out_if.status) overflows_seen++;
				if (decoded_q.size() == 0) begin
					report_mismatch("result with nothing expected; out_byte", out_if.out_byte, 0);
				end else begin
					want = decoded_q.pop_front();
					if (out_if.out_byte !== want.data)
						report_mismatch("out_byte", out_if.out_byte, want.data);
					if (out_if.status !== want.err)
						report_mismatch("status", out_if.status, want.err);
					if (out_if.out_last !== want.last)
						report_mismatch("out_last", out_if.out_last, want.last);
					if (out_if.out_count !== want.count)
						report_mismatch("out_count", out_if.out_count, want.count);
				end
			end
			rx_tick <= rx_tick + 1;
			if (hold_left != 0) begin
				hold_left    <= hold_left - 1;
				out_if.ready <= 1'b0;
			end else if (hold_req && !hold_done) begin
				// One long hold-off so the block fills up and stalls its input.
				hold_left    <= LONG_HOLD - 1;
				hold_done    <= 1'b1;
				out_if.ready <= 1'b0;
			end else begin
				if (rx_left == 0) begin
					rx_style <= rx_style_t'($urandom_range(0, 3));
					rx_left  <= $urandom_range(4, 50);
				end else begin
					rx_left <= rx_left - 1;
				end
				case (rx_style)
					RX_FREE: out_if.ready <= 1'b1;
					RX_COIN: out_if.ready <= 1'($urandom_range(0, 1));
					RX_SPARSE: out_if.ready <= ($urandom_range(0, 3) == 0);
					default: out_if.ready <= (rx_tick % 5) != 0;
				endcase
			end
		end
	end

	always @(posedge clk) begin : watchdog
		if (!arst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("Watchdog: no word moved for %0d cycles", idle_cycles);
			$display("Mismatches found");
			$finish;
		end
	end

	initial begin : stimulus
		logic [15:0] caps[6];
		arst_n <= 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Directed strings at the reset capacity: plus, escapes with digits,
		// blank, sign and junk, a query tail, endings inside an escape and
		// the extreme character codes.
		push_text("x+%41");
		push_text("% 9%-1");
		push_text("%zZ?%+");
		push_text("%7");
		push_text("%");
		push_char(8'h01, 1'b0);
		push_char(8'hFF, 1'b1);
		push_random_chars(220);

		caps = '{16'd0, 16'd1, 16'd2, 16'd7, 16'($urandom_range(3, 24)), CAP_MAX};
		foreach (caps[k]) begin
			write_capacity(caps[k]);
			if (k == 3) begin
				sender_gapless = 1'b1;
				hold_req       = 1'b1;
			end
			push_random_chars((caps[k] == 0) ? 120 : 200);
			if (k == 3) begin
				wait_drained();
				sender_gapless = 1'b0;
			end
		end

		// A short string back to back at the largest capacity closes the run.
		wait_drained();
		sender_gapless = 1'b1;
		push_text("ok+%3f");
		wait_drained();

		$display("Run covered %0d characters and %0d decoded words (%0d overflows)",
			chars_accepted, results_seen, overflows_seen);
		$display("over %0d capacity writes; the input was held back on %0d cycles.",
			capacity_writes, input_stalls);
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
